// ----- rtl/core/block_bitmap_find_and_set_top_defines.svh -----
// Assertion macros for the block bitmap find-and-set checker.
// No dependencies; included by the checker file only.
`ifndef BLOCK_BITMAP_FIND_AND_SET_TOP_DEFINES_SVH
`define BLOCK_BITMAP_FIND_AND_SET_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BBFS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BBFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bbfs_pkg.sv -----
// Shared types, constants and helpers for the block bitmap find-and-set block.
// No dependencies.
`timescale 1ns / 1ps

package bbfs_pkg;

    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int BYTE_W     = 8;
    localparam int ROW_BYTES  = 8;
    localparam int ROW_BITS   = ROW_BYTES * BYTE_W;
    localparam int OFF_W      = 6;
    localparam int BYTE_IDX_W = 3;
    localparam int BIT_IDX_W  = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic FUNC_FIND = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic find_step;
        logic set_read;
        logic set_write;
        logic load_out;
    } bbfs_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_error;
        logic in_set;
        logic scan_done;
    } bbfs_sts_t;

    // Lowest set bit of a row: first non-empty byte, then bit within it
    function automatic logic [OFF_W-1:0] first_one(input logic [ROW_BITS-1:0] v);
        logic [BYTE_IDX_W-1:0] b;
        logic [BIT_IDX_W-1:0]  k;
        logic [BYTE_W-1:0]     sel;
        b = '0;
        k = '0;
        for (int i = ROW_BYTES - 1; i >= 0; i--) begin
            if (|v[i*BYTE_W +: BYTE_W]) begin
                b = BYTE_IDX_W'(i);
            end
        end
        sel = v[{b, 3'b000} +: BYTE_W];
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            if (sel[j]) begin
                k = BIT_IDX_W'(j);
            end
        end
        return {b, k};
    endfunction

endpackage

// ----- rtl/core/block_bitmap_find_and_set_top.sv -----
// Channel   | handshake            | payload
// s_ (in)   | s_valid / s_ready    | s_func, s_position, s_bit_value
// m_ (out)  | m_valid / m_ready    | m_error, m_found, m_found_index, m_entry_byte
// cfg       | cfg_valid / cfg_ready| cfg_data (bits_in_use)
//
// One item at a time. Find scans 64-bit rows from the start row to the hit or last
// valid row (at most 16 at 1024 bits); one row per cycle, set by the single map
// read port. Set: a row read, then a row write. After reset a clearing pass writes
// one row a cycle, all MAX_BITS/64 rows (16), with s_ready low. A finished item
// waits in the result registers until the output register is free; s_ready rises
// again once it is loaded there, so the next item is taken while it is stalled.
// Depends on bbfs_pkg, bbfs_ctrl, bbfs_dp, bbfs_ram.
`timescale 1ns / 1ps

module block_bitmap_find_and_set_top import bbfs_pkg::*; #(
    parameter int MAX_BITS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [POS_W-1:0]  s_position,
    input  logic              s_bit_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_error,
    output logic              m_found,
    output logic [POS_W-1:0]  m_found_index,
    output logic [BYTE_W-1:0] m_entry_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    bbfs_cmd_t cmd;
    bbfs_sts_t sts;

    assign cfg_ready = 1'b1;

    bbfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bbfs_dp #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_func        (s_func),
        .s_position    (s_position),
        .s_bit_value   (s_bit_value),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .m_error       (m_error),
        .m_found       (m_found),
        .m_found_index (m_found_index),
        .m_entry_byte  (m_entry_byte)
    );

endmodule

// ----- rtl/core/bbfs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bbfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bbfs_ctrl.sv -----
// Controller FSM: clearing pass, request sequencing and result handshake.
// Depends on bbfs_pkg.
`timescale 1ns / 1ps

module bbfs_ctrl import bbfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bbfs_sts_t sts,
    output bbfs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_SET_RD,
        ST_SET_WR,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (sts.in_error) begin
                        state_next = ST_DONE;
                    end else if (sts.in_set) begin
                        state_next = ST_SET_RD;
                    end else begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                cmd.find_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_SET_RD: begin
                cmd.set_read = 1'b1;
                state_next   = ST_SET_WR;
            end
            ST_SET_WR: begin
                cmd.set_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/bbfs_dp.sv -----
// Datapath: bit map store, row scan, bit write, count register and result registers.
// Depends on bbfs_pkg and bbfs_ram.
`timescale 1ns / 1ps

module bbfs_dp import bbfs_pkg::*; #(
    parameter int MAX_BITS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bbfs_cmd_t         cmd,
    output bbfs_sts_t         sts,
    input  logic              s_func,
    input  logic [POS_W-1:0]  s_position,
    input  logic              s_bit_value,
    input  logic              cfg_wr,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              m_error,
    output logic              m_found,
    output logic [POS_W-1:0]  m_found_index,
    output logic [BYTE_W-1:0] m_entry_byte
);

    localparam int ROWS  = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = ($clog2(MAX_BITS + 1) > CFG_W) ? $clog2(MAX_BITS + 1) : CFG_W;

    logic [CFG_W-1:0]    bits_in_use_reg;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    pos_ext;
    logic [CNT_W-1:0]    last_bit;
    logic [CNT_W-1:0]    hit_pos;

    logic [RA_W-1:0]     clr_row_reg;
    logic [RA_W-1:0]     rd_row_reg;
    logic [RA_W-1:0]     ev_row_reg;
    logic                ev_valid_reg;
    logic [RA_W-1:0]     start_row_reg;
    logic [OFF_W-1:0]    start_off_reg;
    logic [RA_W-1:0]     last_row_reg;
    logic [OFF_W-1:0]    last_off_reg;
    logic                bit_reg;

    logic                res_error_reg;
    logic                res_found_reg;
    logic [POS_W-1:0]    res_idx_reg;
    logic [BYTE_W-1:0]   res_entry_reg;

    logic                out_error_reg;
    logic                out_found_reg;
    logic [POS_W-1:0]    out_idx_reg;
    logic [BYTE_W-1:0]   out_entry_reg;

    logic                ram_we;
    logic [RA_W-1:0]     ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [ROW_BITS-1:0] ram_rdata;

    logic [ROW_BITS-1:0] match;
    logic [ROW_BITS-1:0] lo_mask;
    logic [ROW_BITS-1:0] hi_mask;
    logic [ROW_BITS-1:0] cand;
    logic                hit;
    logic [OFF_W-1:0]    hit_off;

    logic [BYTE_W-1:0]   old_byte;
    logic [BYTE_W-1:0]   bit_mask;
    logic [BYTE_W-1:0]   new_byte;
    logic [ROW_BITS-1:0] new_row;

    // Counts above the map size saturate
    assign count    = (CNT_W'(bits_in_use_reg) > CNT_W'(MAX_BITS)) ?
                      CNT_W'(MAX_BITS) : CNT_W'(bits_in_use_reg);
    assign pos_ext  = CNT_W'(s_position);
    assign last_bit = count - CNT_W'(1);

    assign sts.clr_done  = (clr_row_reg == RA_W'(ROWS - 1));
    assign sts.in_error  = (pos_ext >= count);
    assign sts.in_set    = (s_func == FUNC_SET);
    assign sts.scan_done = ev_valid_reg && (hit || (ev_row_reg == last_row_reg));

    // Scan: bits below the start and past the last valid bit are masked
    assign match   = bit_reg ? ram_rdata : ~ram_rdata;
    assign lo_mask = {ROW_BITS{1'b1}} << start_off_reg;
    assign hi_mask = {ROW_BITS{1'b1}} >> (OFF_W'(ROW_BITS - 1) - last_off_reg);
    assign cand    = match
                   & ((ev_row_reg == start_row_reg) ? lo_mask : {ROW_BITS{1'b1}})
                   & ((ev_row_reg == last_row_reg)  ? hi_mask : {ROW_BITS{1'b1}});
    assign hit     = |cand;
    assign hit_off = first_one(cand);
    assign hit_pos = (CNT_W'(ev_row_reg) << OFF_W) | CNT_W'(hit_off);

    // Bit write: read-modify-write of the row holding the entry
    assign old_byte = ram_rdata[{start_off_reg[OFF_W-1:BIT_IDX_W], 3'b000} +: BYTE_W];
    assign bit_mask = BYTE_W'(1) << start_off_reg[BIT_IDX_W-1:0];
    assign new_byte = bit_reg ? (old_byte | bit_mask) : (old_byte & ~bit_mask);

    always_comb begin
        for (int b = 0; b < ROW_BYTES; b++) begin
            new_row[b*BYTE_W +: BYTE_W] =
                (BYTE_IDX_W'(b) == start_off_reg[OFF_W-1:BIT_IDX_W]) ?
                new_byte : ram_rdata[b*BYTE_W +: BYTE_W];
        end
    end

    assign ram_we    = cmd.clr_step || cmd.set_write;
    assign ram_waddr = cmd.clr_step ? clr_row_reg : rd_row_reg;
    assign ram_wdata = cmd.clr_step ? '0 : new_row;
    assign ram_re    = cmd.find_step || cmd.set_read;

    bbfs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_row_reg),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_in_use_reg <= CFG_RESET;
            clr_row_reg     <= '0;
            ev_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                bits_in_use_reg <= cfg_data;
            end
            if (cmd.clr_step && !sts.clr_done) begin
                clr_row_reg <= clr_row_reg + RA_W'(1);
            end
            if (cmd.accept) begin
                ev_valid_reg <= 1'b0;
            end else if (cmd.find_step) begin
                ev_valid_reg <= 1'b1;
            end
        end
    end

    // Request and result registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_row_reg    <= pos_ext[RA_W+OFF_W-1:OFF_W];
            start_row_reg <= pos_ext[RA_W+OFF_W-1:OFF_W];
            start_off_reg <= pos_ext[OFF_W-1:0];
            last_row_reg  <= last_bit[RA_W+OFF_W-1:OFF_W];
            last_off_reg  <= last_bit[OFF_W-1:0];
            bit_reg       <= s_bit_value;
            res_error_reg <= sts.in_error;
            res_found_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_entry_reg <= '0;
        end
        if (cmd.find_step) begin
            ev_row_reg <= rd_row_reg;
            // hold on the last row; the repeat read is never evaluated
            if (rd_row_reg != last_row_reg) begin
                rd_row_reg <= rd_row_reg + RA_W'(1);
            end
            if (ev_valid_reg && hit) begin
                res_found_reg <= 1'b1;
                res_idx_reg   <= hit_pos[POS_W-1:0];
            end
        end
        if (cmd.set_write) begin
            res_entry_reg <= new_byte;
        end
        if (cmd.load_out) begin
            out_error_reg <= res_error_reg;
            out_found_reg <= res_found_reg;
            out_idx_reg   <= res_idx_reg;
            out_entry_reg <= res_entry_reg;
        end
    end

    assign m_error       = out_error_reg;
    assign m_found       = out_found_reg;
    assign m_found_index = out_idx_reg;
    assign m_entry_byte  = out_entry_reg;

endmodule

// ----- rtl/core/bbfs_chk.sv -----
// Port-level checker for the block bitmap find-and-set top, with its bind.
// Depends on bbfs_pkg and block_bitmap_find_and_set_top_defines.svh.
`timescale 1ns / 1ps
`include "block_bitmap_find_and_set_top_defines.svh"

module bbfs_chk import bbfs_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_func,
    input logic [POS_W-1:0]  s_position,
    input logic              s_bit_value,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_error,
    input logic              m_found,
    input logic [POS_W-1:0]  m_found_index,
    input logic [BYTE_W-1:0] m_entry_byte,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CFG_W-1:0]  cfg_data
);

    // stalled result holds
    `BBFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_found_index) && $stable(m_entry_byte) && $stable(m_error),
        "stalled result item changed")

    // an error item carries no other result
    `BBFS_ASSERT_NOW(a_err_clean, aclk, aresetn, m_valid && m_error,
        !m_found && m_found_index == '0 && m_entry_byte == '0,
        "error item has result fields set")

    // find and set results never mix
    `BBFS_ASSERT_NOW(a_find_clean, aclk, aresetn, m_valid && m_found,
        !m_error && m_entry_byte == '0,
        "found item carries entry byte or error")

    // one item in work at a time
    `BBFS_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready,
        !s_ready,
        "input taken on consecutive cycles")

endmodule

bind block_bitmap_find_and_set_top bbfs_chk u_bbfs_chk (.*);

// ----- bench/tb_block_bitmap_find_and_set_top.sv -----
// Self-checking bench for block_bitmap_find_and_set_top: find and set requests against
// a shadow bitmap, with random source gaps, sink stalls and several bits-in-use counts.
// Depends on bbfs_pkg and the RTL of block_bitmap_find_and_set_top.
`timescale 1ns / 1ps

module tb_block_bitmap_find_and_set_top;
    import bbfs_pkg::*;

    localparam int MAP_BITS    = 1024;
    localparam int MAP_ENTRIES = MAP_BITS / BYTE_W;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
        logic             bit_value;
    } bitmap_req_t;

    typedef struct packed {
        logic              error;
        logic              found;
        logic [POS_W-1:0]  found_index;
        logic [BYTE_W-1:0] entry_byte;
    } bitmap_res_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_func = FUNC_FIND;
    logic [POS_W-1:0]  s_position = '0;
    logic              s_bit_value = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_error;
    logic              m_found;
    logic [POS_W-1:0]  m_found_index;
    logic [BYTE_W-1:0] m_entry_byte;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    bitmap_req_t       pending_requests[$];
    bitmap_res_t       expected_results[$];
    logic [BYTE_W-1:0] shadow_map[MAP_ENTRIES];
    logic [CFG_W-1:0]  shadow_limit = CFG_RESET;

    bitmap_req_t       next_req;
    bitmap_res_t       got_res;
    bitmap_res_t       want_res;
    logic              s_taken = 1'b0;
    int unsigned       src_gap = 0;
    int unsigned       sink_stall = 0;
    bit                src_idle_on = 1'b1;
    bit                sink_idle_on = 1'b1;
    int unsigned       mismatch_count = 0;

    block_bitmap_find_and_set_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_position    (s_position),
        .s_bit_value   (s_bit_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_error       (m_error),
        .m_found       (m_found),
        .m_found_index (m_found_index),
        .m_entry_byte  (m_entry_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("** block_bitmap_find_and_set_top: FAILED **");
        $finish;
    end

    // Applies one request to the shadow map and returns the result the block should give
    function automatic bitmap_res_t predict_request(bitmap_req_t r);
        bitmap_res_t       res;
        int unsigned       span;
        int unsigned       p;
        logic [BYTE_W-1:0] e;
        res  = '0;
        span = (shadow_limit > MAP_BITS) ? MAP_BITS : shadow_limit;
        if (r.position >= span) begin
            res.error = 1'b1;
            return res;
        end
        if (r.func == FUNC_FIND) begin
            // never look past the count, even inside the last entry
            for (p = r.position; p < span; p++) begin
                if (shadow_map[p / BYTE_W][p % BYTE_W] == r.bit_value) begin
                    res.found       = 1'b1;
                    res.found_index = POS_W'(p);
                    break;
                end
            end
        end else begin
            e = shadow_map[r.position / BYTE_W];
            e[r.position % BYTE_W] = r.bit_value;
            shadow_map[r.position / BYTE_W] = e;
            res.entry_byte = e;
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic bitmap_req_t random_request(int unsigned limit, int unsigned ones_pct);
        bitmap_req_t r;
        int unsigned span;
        int unsigned sel;
        int unsigned reach;
        span = (limit > MAP_BITS) ? MAP_BITS : limit;
        sel  = $urandom_range(0, 99);
        r.func = ($urandom_range(0, 99) < 50) ? FUNC_SET : FUNC_FIND;
        if (r.func == FUNC_SET) begin
            r.bit_value = ($urandom_range(0, 99) < ones_pct);
        end else begin
            r.bit_value = 1'($urandom_range(0, 1));
        end
        if (span == 0 || sel < 10) begin
            r.position = POS_W'($urandom_range(0, MAP_BITS - 1));
        end else if (sel < 25) begin
            // cluster near the top of the count
            reach = (span > 10) ? 9 : span - 1;
            r.position = POS_W'(span - 1 - $urandom_range(0, reach));
        end else begin
            r.position = POS_W'($urandom_range(0, span - 1));
        end
        return r;
    endfunction

    // Tracks accepted items and config writes, checks every result in order
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                shadow_limit = cfg_data;
            end
            if (m_valid && m_ready) begin
                got_res = '{m_error, m_found, m_found_index, m_entry_byte};
                if (expected_results.size() == 0) begin
                    $error("unexpected item on m_ channel");
                    mismatch_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.error !== want_res.error) begin
                        $error("m_error: expected %0d, got %0d", want_res.error, got_res.error);
                        mismatch_count++;
                    end
                    if (got_res.found !== want_res.found) begin
                        $error("m_found: expected %0d, got %0d", want_res.found, got_res.found);
                        mismatch_count++;
                    end
                    if (got_res.found_index !== want_res.found_index) begin
                        $error("m_found_index: expected %0d, got %0d",
                               want_res.found_index, got_res.found_index);
                        mismatch_count++;
                    end
                    if (got_res.entry_byte !== want_res.entry_byte) begin
                        $error("m_entry_byte: expected 0x%02h, got 0x%02h",
                               want_res.entry_byte, got_res.entry_byte);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_request('{s_func, s_position, s_bit_value}));
            end
        end
    end

    // Source side: hold each item until taken, then an optional gap
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (pending_requests.size() > 0) begin
                next_req = pending_requests.pop_front();
                s_func      <= next_req.func;
                s_position  <= next_req.position;
                s_bit_value <= next_req.bit_value;
                s_valid     <= 1'b1;
                src_gap     <= src_idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sink side back-pressure
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            m_ready    <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            sink_stall <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_request(logic func, int unsigned pos, logic val);
        bitmap_req_t r;
        r.func      = func;
        r.position  = POS_W'(pos);
        r.bit_value = val;
        pending_requests.push_back(r);
    endtask

    // sampled at the rising edge, where the source side has settled
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (24) @(negedge aclk);
    endtask

    task automatic write_limit(int unsigned value);
        wait_drained();
        cfg_data  <= CFG_W'(value);
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int unsigned limit, int unsigned count);
        int unsigned ones_pct;
        write_limit(limit);
        ones_pct     = $urandom_range(5, 95);
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            pending_requests.push_back(random_request(limit, ones_pct));
        end
    endtask

    initial begin
        for (int i = 0; i < MAP_ENTRIES; i++) begin
            shadow_map[i] = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset count, empty map: full scans with and without a hit
        queue_request(FUNC_FIND, 0, 1'b0);
        queue_request(FUNC_FIND, 0, 1'b1);
        queue_request(FUNC_FIND, 1023, 1'b1);
        queue_request(FUNC_SET, 1023, 1'b1);
        queue_request(FUNC_FIND, 0, 1'b1);
        queue_request(FUNC_FIND, 1023, 1'b0);
        queue_request(FUNC_SET, 0, 1'b1);
        queue_request(FUNC_SET, 7, 1'b1);
        queue_request(FUNC_SET, 0, 1'b0);
        queue_request(FUNC_SET, 13, 1'b1);
        queue_request(FUNC_SET, 14, 1'b1);
        queue_request(FUNC_SET, 15, 1'b1);
        queue_request(FUNC_FIND, 8, 1'b1);

        // partial last entry: set bits above the count must stay invisible
        write_limit(13);
        queue_request(FUNC_FIND, 8, 1'b1);
        queue_request(FUNC_FIND, 7, 1'b0);
        queue_request(FUNC_SET, 12, 1'b1);
        queue_request(FUNC_FIND, 8, 1'b1);
        queue_request(FUNC_SET, 13, 1'b0);
        queue_request(FUNC_FIND, 1023, 1'b1);

        write_limit(0);
        queue_request(FUNC_FIND, 0, 1'b0);
        queue_request(FUNC_SET, 0, 1'b1);

        // count above the map size saturates
        write_limit(2047);
        queue_request(FUNC_FIND, 16, 1'b1);
        queue_request(FUNC_SET, 1023, 1'b0);

        write_limit(1);
        queue_request(FUNC_FIND, 0, 1'b1);
        queue_request(FUNC_SET, 0, 1'b1);
        queue_request(FUNC_FIND, 1, 1'b1);

        run_random(1024, 150);
        run_random(2047, 150);
        run_random(1023, 150);
        run_random(37, 150);
        run_random(1025, 150);
        run_random(8, 150);
        run_random(600, 150);
        run_random($urandom_range(0, 2047), 150);

        wait_drained();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("** block_bitmap_find_and_set_top: PASSED **");
        end else begin
            $display("** block_bitmap_find_and_set_top: FAILED **");
        end
        $finish;
    end

endmodule
